/* rtl/video_memory_dirty_block_tracker_defines.svh */
// Assertion macros used by the tracker top level.
// Each macro checks a property on every rising edge of the given clock while
// the active-low reset is released.
`ifndef VIDEO_MEMORY_DIRTY_BLOCK_TRACKER_DEFINES_SVH
`define VIDEO_MEMORY_DIRTY_BLOCK_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define VMDBT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("vmdbt: invariant violated");
`define VMDBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmdbt: sequence violated");
`else
`define VMDBT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define VMDBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/vmdbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vmdbt_pkg;

    // Block geometry. NUM_BLOCKS must be a power of two.
    localparam int BLOCK_SHIFT = 8;
    localparam int NUM_BLOCKS  = 8192;

    // Fixed field widths of an item.
    localparam int OP_W     = 2;
    localparam int OFFSET_W = 21;
    localparam int COUNT_W  = 23;
    localparam int MARK_W   = 2;

    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_RAW_W = COUNT_W + 1 - BLOCK_SHIFT;
    localparam int CNT_W     = (CNT_RAW_W > BLK_W + 1) ? CNT_RAW_W : BLK_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_MARK_RANGE = 2'd0,
        OP_MARK_ALL   = 2'd1,
        OP_QUERY      = 2'd2
    } t_op;

    typedef enum logic [MARK_W-1:0] {
        MARK_CLEAN   = 2'd0,
        MARK_UNKNOWN = 2'd1,
        MARK_DIRTY   = 2'd2,
        MARK_DRAWN   = 2'd3
    } t_mark;

    // What the write-back stage does with the mark it has read.
    typedef enum logic [1:0] {
        MODE_CLEAR,
        MODE_SET,
        MODE_PROMOTE,
        MODE_QUERY
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // One block in flight between the memory read and the write-back.
    typedef struct packed {
        logic             valid;
        t_mode            mode;
        logic             first;
        logic             last;
        logic [BLK_W-1:0] addr;
    } t_stage;

    // Per-item context held for the whole walk.
    typedef struct packed {
        t_mark mark;
        logic  start_even;
        logic  end_even;
    } t_ctx;

    typedef struct packed {
        logic acc_clr;
        logic done;
        logic report;
    } t_seq_status;

    typedef struct packed {
        logic unknown_seen;
        logic dirty_seen;
        logic drawn_seen;
    } t_scan;

endpackage

`default_nettype wire

/* rtl/video_memory_dirty_block_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Dirty-block tracker for a video memory split into 8192 blocks of 256 bytes.
// An item is accepted on a rising edge with i_start high and o_busy low. Every
// item, whatever its operation, returns exactly one result, shown on the flag
// ports for a single cycle while o_done is high; there is no way to hold a
// result off, so the receiver must take it in that cycle. The marks live in a
// single-port-per-direction memory that is read once per cycle, so an item
// that covers N blocks keeps o_busy high while it reads each block, lets the
// last write-back land and reports; o_done rises as o_busy falls, and a new
// item may be accepted in that same cycle. Mark all, and a mark range that
// runs past the last block, walk all 8192 blocks. Items that touch no block
// (an empty range, a query that reaches the last block, the unused operation
// code) skip the walk and go straight to the report. After reset the block
// clears the whole memory to clean, one block a cycle, and holds o_busy high
// through the clear and a flush step before it takes its first item. Flags
// are meaningful only for a query; for everything else they read zero.

`include "video_memory_dirty_block_tracker_defines.svh"

module video_memory_dirty_block_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [vmdbt_pkg::OP_W-1:0]     i_operation,
    input  wire logic [vmdbt_pkg::OFFSET_W-1:0] i_byte_offset,
    input  wire logic [vmdbt_pkg::COUNT_W-1:0]  i_byte_count,
    input  wire logic [vmdbt_pkg::MARK_W-1:0]   i_mark_value,
    input  wire logic                           i_is_target,
    input  wire logic                           i_shadow_matches,
    output logic                                o_busy,
    output logic                                o_done,
    output logic                                o_target_flag,
    output logic                                o_unchanged_flag,
    output logic                                o_drawn_flag
);

    logic                        busy;
    logic                        rd_en;
    logic [vmdbt_pkg::BLK_W-1:0] rd_addr;
    vmdbt_pkg::t_mark            rd_data;
    logic                        wr_en;
    logic [vmdbt_pkg::BLK_W-1:0] wr_addr;
    vmdbt_pkg::t_mark            wr_data;
    vmdbt_pkg::t_stage           stage;
    vmdbt_pkg::t_ctx             ctx;
    vmdbt_pkg::t_seq_status      status;
    vmdbt_pkg::t_scan            scan;

    // Query inputs that are only needed when the result is formed.
    logic r_target;
    logic r_shadow;

    logic r_done;
    logic r_target_flag;
    logic r_unchanged_flag;
    logic r_drawn_flag;
    logic unchanged;

    vmdbt_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_operation  (i_operation),
        .i_byte_offset(i_byte_offset),
        .i_byte_count (i_byte_count),
        .i_mark_value (i_mark_value),
        .o_busy       (busy),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_stage      (stage),
        .o_ctx        (ctx),
        .o_status     (status)
    );

    vmdbt_ram u_ram (
        .i_clk    (i_clk),
        .i_rd_addr(rd_addr),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .o_rd_data(rd_data)
    );

    vmdbt_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (stage),
        .i_ctx    (ctx),
        .i_acc_clr(status.acc_clr),
        .i_rd_data(rd_data),
        .o_wr_en  (wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data),
        .o_scan   (scan)
    );

    always_ff @(posedge i_clk) begin
        if (!busy && i_start) begin
            r_target <= i_is_target;
            r_shadow <= i_shadow_matches;
        end
    end

    // A range whose last non-clean block is unknown still counts as
    // unchanged when the shadow copy matches memory.
    assign unchanged = !(scan.dirty_seen && !(scan.unknown_seen && r_shadow));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= status.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.done) begin
            r_target_flag    <= status.report && r_target;
            r_unchanged_flag <= status.report && unchanged;
            r_drawn_flag     <= status.report && scan.drawn_seen;
        end
    end

    assign o_busy           = busy;
    assign o_done           = r_done;
    assign o_target_flag    = r_target_flag;
    assign o_unchanged_flag = r_unchanged_flag;
    assign o_drawn_flag     = r_drawn_flag;

    // An accepted item always makes the sequencer busy.
    `VMDBT_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // Results are single-cycle strobes, never back to back.
    `VMDBT_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    // The walk never reads the block that is being written back.
    `VMDBT_ASSERT_ALWAYS(a_no_rd_wr_clash, i_clk, i_rst_n, !(rd_en && wr_en && rd_addr == wr_addr))

endmodule

`default_nettype wire

/* rtl/vmdbt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Mark store: one write port and one read port, read data registered.
module vmdbt_ram (
    input  wire logic                        i_clk,
    input  wire logic [vmdbt_pkg::BLK_W-1:0] i_rd_addr,
    input  wire logic                        i_wr_en,
    input  wire logic [vmdbt_pkg::BLK_W-1:0] i_wr_addr,
    input  wire vmdbt_pkg::t_mark            i_wr_data,
    output vmdbt_pkg::t_mark                 o_rd_data
);

    vmdbt_pkg::t_mark r_mem [vmdbt_pkg::NUM_BLOCKS];
    vmdbt_pkg::t_mark r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/vmdbt_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// Write-back stage: turns the mark just read into the mark to store and
// folds it into the query flags.
module vmdbt_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire vmdbt_pkg::t_stage           i_stage,
    input  wire vmdbt_pkg::t_ctx             i_ctx,
    input  wire logic                        i_acc_clr,
    input  wire vmdbt_pkg::t_mark            i_rd_data,
    output logic                             o_wr_en,
    output logic [vmdbt_pkg::BLK_W-1:0]      o_wr_addr,
    output vmdbt_pkg::t_mark                 o_wr_data,
    output vmdbt_pkg::t_scan                 o_scan
);

    vmdbt_pkg::t_scan r_scan;
    vmdbt_pkg::t_scan n_scan;
    logic             cleanable;

    always_comb begin
        cleanable = (i_rd_data == vmdbt_pkg::MARK_UNKNOWN ||
                     i_rd_data == vmdbt_pkg::MARK_DIRTY) &&
                    (!i_stage.first || i_ctx.start_even) &&
                    (!i_stage.last || i_ctx.end_even);
        case (i_stage.mode)
            vmdbt_pkg::MODE_CLEAR:   o_wr_data = vmdbt_pkg::MARK_CLEAN;
            vmdbt_pkg::MODE_SET:     o_wr_data = i_ctx.mark;
            vmdbt_pkg::MODE_PROMOTE: o_wr_data = (i_rd_data == vmdbt_pkg::MARK_CLEAN) ?
                                                 vmdbt_pkg::MARK_UNKNOWN : i_rd_data;
            default:                 o_wr_data = cleanable ? vmdbt_pkg::MARK_CLEAN : i_rd_data;
        endcase
    end

    assign o_wr_en   = i_stage.valid;
    assign o_wr_addr = i_stage.addr;

    always_comb begin
        n_scan = r_scan;
        if (i_acc_clr) begin
            n_scan = '0;
        end else if (i_stage.valid && i_stage.mode == vmdbt_pkg::MODE_QUERY) begin
            // The unknown run restarts at any dirty or drawn block.
            n_scan.unknown_seen = (r_scan.unknown_seen ||
                                   i_rd_data == vmdbt_pkg::MARK_UNKNOWN) &&
                                  i_rd_data != vmdbt_pkg::MARK_DIRTY &&
                                  i_rd_data != vmdbt_pkg::MARK_DRAWN;
            n_scan.dirty_seen   = r_scan.dirty_seen || i_rd_data != vmdbt_pkg::MARK_CLEAN;
            n_scan.drawn_seen   = r_scan.drawn_seen || i_rd_data == vmdbt_pkg::MARK_DRAWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

/* rtl/vmdbt_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: decodes an item into a block walk and issues one memory read
// per cycle, then lets the last write-back land before reporting.
module vmdbt_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [vmdbt_pkg::OP_W-1:0]     i_operation,
    input  wire logic [vmdbt_pkg::OFFSET_W-1:0] i_byte_offset,
    input  wire logic [vmdbt_pkg::COUNT_W-1:0]  i_byte_count,
    input  wire logic [vmdbt_pkg::MARK_W-1:0]   i_mark_value,
    output logic                                o_busy,
    output logic                                o_rd_en,
    output logic [vmdbt_pkg::BLK_W-1:0]         o_rd_addr,
    output vmdbt_pkg::t_stage                   o_stage,
    output vmdbt_pkg::t_ctx                     o_ctx,
    output vmdbt_pkg::t_seq_status              o_status
);

    localparam int SPAN_W = vmdbt_pkg::CNT_W + 1;

    vmdbt_pkg::t_state            r_state, n_state;
    logic [vmdbt_pkg::BLK_W-1:0]  r_addr, n_addr;
    logic [vmdbt_pkg::CNT_W-1:0]  r_left, n_left;
    logic                         r_first, n_first;
    logic                         r_item, n_item;
    logic                         r_report, n_report;
    vmdbt_pkg::t_mode             r_mode, n_mode;
    vmdbt_pkg::t_ctx              r_ctx, n_ctx;
    vmdbt_pkg::t_stage            r_stage;

    logic [vmdbt_pkg::OFFSET_W-1:0]    offset_blk;
    logic [vmdbt_pkg::BLK_W-1:0]       first_blk;
    logic [vmdbt_pkg::COUNT_W:0]       count_round;
    logic [vmdbt_pkg::COUNT_W:0]       count_shift;
    logic [vmdbt_pkg::CNT_W-1:0]       blk_count;
    logic [SPAN_W-1:0]                 span_end;
    logic [vmdbt_pkg::BLOCK_SHIFT-1:0] end_low;
    logic                              rd_en;
    logic                              acc_clr;
    logic                              done;
    vmdbt_pkg::t_mode                  all_mode;

    // Range geometry of the offered item.
    always_comb begin
        offset_blk  = i_byte_offset >> vmdbt_pkg::BLOCK_SHIFT;
        first_blk   = offset_blk[vmdbt_pkg::BLK_W-1:0];
        count_round = {1'b0, i_byte_count} +
                      (vmdbt_pkg::COUNT_W+1)'((1 << vmdbt_pkg::BLOCK_SHIFT) - 1);
        count_shift = count_round >> vmdbt_pkg::BLOCK_SHIFT;
        blk_count   = vmdbt_pkg::CNT_W'(count_shift);
        span_end    = SPAN_W'(first_blk) + SPAN_W'(blk_count);
        end_low     = i_byte_offset[vmdbt_pkg::BLOCK_SHIFT-1:0] +
                      i_byte_count[vmdbt_pkg::BLOCK_SHIFT-1:0];
        all_mode    = (vmdbt_pkg::t_mark'(i_mark_value) == vmdbt_pkg::MARK_UNKNOWN) ?
                      vmdbt_pkg::MODE_PROMOTE : vmdbt_pkg::MODE_SET;
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_left   = r_left;
        n_first  = r_first;
        n_item   = r_item;
        n_report = r_report;
        n_mode   = r_mode;
        n_ctx    = r_ctx;
        rd_en    = 1'b0;
        acc_clr  = 1'b0;
        done     = 1'b0;
        unique case (r_state)
            vmdbt_pkg::ST_CLEAR: begin
                rd_en  = 1'b1;
                n_addr = vmdbt_pkg::BLK_W'(r_addr + 1'b1);
                if (r_addr == vmdbt_pkg::BLK_W'(vmdbt_pkg::NUM_BLOCKS - 1)) begin
                    n_state = vmdbt_pkg::ST_FLUSH;
                end
            end
            vmdbt_pkg::ST_IDLE: begin
                if (i_start) begin
                    acc_clr        = 1'b1;
                    n_item         = 1'b1;
                    n_first        = 1'b1;
                    n_report       = 1'b0;
                    n_ctx.mark     = vmdbt_pkg::t_mark'(i_mark_value);
                    n_ctx.start_even = (i_byte_offset[vmdbt_pkg::BLOCK_SHIFT-1:0] == '0);
                    n_ctx.end_even = (end_low == '0);
                    n_state        = vmdbt_pkg::ST_DONE;
                    unique case (vmdbt_pkg::t_op'(i_operation))
                        vmdbt_pkg::OP_MARK_RANGE: begin
                            if (span_end > SPAN_W'(vmdbt_pkg::NUM_BLOCKS)) begin
                                n_addr  = '0;
                                n_left  = vmdbt_pkg::CNT_W'(vmdbt_pkg::NUM_BLOCKS);
                                n_mode  = all_mode;
                                n_state = vmdbt_pkg::ST_WALK;
                            end else begin
                                n_addr = first_blk;
                                n_left = blk_count;
                                n_mode = vmdbt_pkg::MODE_SET;
                                if (blk_count != '0) begin
                                    n_state = vmdbt_pkg::ST_WALK;
                                end
                            end
                        end
                        vmdbt_pkg::OP_MARK_ALL: begin
                            n_addr  = '0;
                            n_left  = vmdbt_pkg::CNT_W'(vmdbt_pkg::NUM_BLOCKS);
                            n_mode  = all_mode;
                            n_state = vmdbt_pkg::ST_WALK;
                        end
                        vmdbt_pkg::OP_QUERY: begin
                            // A query that reaches the last block reports nothing.
                            if (span_end < SPAN_W'(vmdbt_pkg::NUM_BLOCKS)) begin
                                n_report = 1'b1;
                                n_addr   = first_blk;
                                n_left   = blk_count;
                                n_mode   = vmdbt_pkg::MODE_QUERY;
                                if (blk_count != '0) begin
                                    n_state = vmdbt_pkg::ST_WALK;
                                end
                            end
                        end
                        default: begin
                            n_state = vmdbt_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            vmdbt_pkg::ST_WALK: begin
                rd_en   = 1'b1;
                n_addr  = vmdbt_pkg::BLK_W'(r_addr + 1'b1);
                n_left  = vmdbt_pkg::CNT_W'(r_left - 1'b1);
                n_first = 1'b0;
                if (r_left == vmdbt_pkg::CNT_W'(1)) begin
                    n_state = vmdbt_pkg::ST_FLUSH;
                end
            end
            vmdbt_pkg::ST_FLUSH: begin
                n_state = r_item ? vmdbt_pkg::ST_DONE : vmdbt_pkg::ST_IDLE;
            end
            vmdbt_pkg::ST_DONE: begin
                done    = 1'b1;
                n_item  = 1'b0;
                n_state = vmdbt_pkg::ST_IDLE;
            end
            default: begin
                n_state = vmdbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vmdbt_pkg::ST_CLEAR;
            r_addr   <= '0;
            r_left   <= '0;
            r_first  <= 1'b0;
            r_item   <= 1'b0;
            r_report <= 1'b0;
            r_mode   <= vmdbt_pkg::MODE_CLEAR;
            r_stage  <= '0;
        end else begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_left        <= n_left;
            r_first       <= n_first;
            r_item        <= n_item;
            r_report      <= n_report;
            r_mode        <= n_mode;
            r_stage.valid <= rd_en;
            r_stage.mode  <= r_mode;
            r_stage.first <= r_first;
            r_stage.last  <= (r_left == vmdbt_pkg::CNT_W'(1));
            r_stage.addr  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx <= n_ctx;
    end

    assign o_busy          = (r_state != vmdbt_pkg::ST_IDLE);
    assign o_rd_en         = rd_en;
    assign o_rd_addr       = r_addr;
    assign o_stage         = r_stage;
    assign o_ctx           = r_ctx;
    assign o_status.acc_clr = acc_clr;
    assign o_status.done   = done;
    assign o_status.report = r_report;

endmodule

`default_nettype wire
